/* rtl/tdq_pkg.sv */
// shared types and codes of the sorted deadline timer queue
`default_nettype none
package tdq_pkg;
    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_CLEAR    = 2'd1;
    localparam logic [1:0] CMD_SET_TIME = 2'd2;
    localparam logic [1:0] CMD_DISPATCH = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_POOL_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;
    localparam logic [1:0] ST_DISABLED   = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] delay_us;
        logic [9:0]  handle_in;
        logic [47:0] time_us;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] handle_out;
        logic       fired;
        logic       last;
    } t_res;

    typedef struct packed {
        logic valid;
        t_res res;
    } t_emit;
endpackage
`default_nettype wire

/* rtl/tdq_ifs.sv */
// channel interfaces of the sorted deadline timer queue
`default_nettype none
interface tdq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] delay_us;
    logic [9:0]  handle_in;
    logic [47:0] time_us;
    modport source(output valid, command, delay_us, handle_in, time_us, input ready);
    modport sink(input valid, command, delay_us, handle_in, time_us, output ready);
endinterface

interface tdq_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [9:0] handle_out;
    logic       fired;
    logic       last;
    modport source(output valid, status, handle_out, fired, last, input ready);
    modport sink(input valid, status, handle_out, fired, last, output ready);
endinterface

interface tdq_cfg_if;
    logic valid;
    logic ready;
    logic timers_disabled;
    modport source(output valid, timers_disabled, input ready);
    modport sink(input valid, timers_disabled, output ready);
endinterface
`default_nettype wire

/* rtl/tdq_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module tdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* rtl/tdq_ctrl.sv */
// sequencer that walks the sorted list and pops and pushes the free list
`default_nettype none
module tdq_ctrl #(
    parameter int NUM_TIMERS = 1024,
    parameter int TIME_BITS  = 48,
    parameter int MAX_FIRE   = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire tdq_pkg::t_cmd                 i_cmd,
    input  wire logic                          i_dis,
    input  wire logic                          i_slot_free,
    output tdq_pkg::t_emit                     o_emit,
    output logic                               o_dl_we,
    output logic [$clog2(NUM_TIMERS)-1:0]      o_dl_waddr,
    output logic [TIME_BITS-1:0]               o_dl_wdata,
    output logic                               o_lk_we,
    output logic [$clog2(NUM_TIMERS)-1:0]      o_lk_waddr,
    output logic [$clog2(NUM_TIMERS)+1:0]      o_lk_wdata,
    output logic [$clog2(NUM_TIMERS)-1:0]      o_raddr,
    input  wire logic [TIME_BITS-1:0]          i_dl_rdata,
    input  wire logic [$clog2(NUM_TIMERS)+1:0] i_lk_rdata
);
    localparam int HW = $clog2(NUM_TIMERS);
    localparam int LW = HW + 1;
    localparam int NW = $clog2(MAX_FIRE + 1);
    localparam logic [LW-1:0] EMPTY    = LW'(NUM_TIMERS);
    localparam logic [LW-1:0] LAST_IDX = LW'(NUM_TIMERS - 1);
    localparam logic [NW-1:0] FIRE_MAX = NW'(MAX_FIRE);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_ADD_POP = 4'd2;
    localparam logic [3:0] S_CLR_CHK = 4'd3;
    localparam logic [3:0] S_WALK    = 4'd4;
    localparam logic [3:0] S_LINK1   = 4'd5;
    localparam logic [3:0] S_LINK2   = 4'd6;
    localparam logic [3:0] S_EMIT    = 4'd7;
    localparam logic [3:0] S_DCHK    = 4'd8;

    function automatic logic [HW-1:0] idx(input logic [LW-1:0] p);
        return (p == EMPTY) ? '0 : p[HW-1:0];
    endfunction

    logic [3:0]           r_state, n_state;
    logic [LW-1:0]        r_ptr, n_ptr;
    logic [LW-1:0]        r_prev, n_prev;
    logic [LW-1:0]        r_head, n_head;
    logic [LW-1:0]        r_free, n_free;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIME_BITS-1:0] r_dl, n_dl;
    logic [HW-1:0]        r_h, n_h;
    logic [LW-1:0]        r_hlink, n_hlink;
    logic                 r_is_add, n_is_add;
    logic [NW-1:0]        r_n, n_n;
    logic [HW-1:0]        r_pend, n_pend;
    logic                 r_pend_v, n_pend_v;
    tdq_pkg::t_res        r_res, n_res;

    logic                 lk_act;
    logic [LW-1:0]        lk_link;
    logic [TIME_BITS:0]   sum;
    logic                 stop;
    logic                 fire;
    logic [LW-1:0]        new_link;

    assign lk_act  = i_lk_rdata[LW];
    assign lk_link = i_lk_rdata[LW-1:0];
    assign sum     = {1'b0, r_now} + (TIME_BITS+1)'(i_cmd.delay_us);
    assign stop    = r_is_add ? (r_ptr == EMPTY || i_dl_rdata >= r_dl)
                              : (r_ptr == EMPTY || r_ptr == {1'b0, r_h});
    assign fire    = (r_ptr != EMPTY) && (i_dl_rdata <= r_now) && (r_n < FIRE_MAX);
    assign new_link = r_is_add ? {1'b0, r_h} : r_hlink;

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_prev   = r_prev;
        n_head   = r_head;
        n_free   = r_free;
        n_now    = r_now;
        n_dl     = r_dl;
        n_h      = r_h;
        n_hlink  = r_hlink;
        n_is_add = r_is_add;
        n_n      = r_n;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_res    = r_res;
        o_in_ready = 1'b0;
        o_emit     = '0;
        o_dl_we    = 1'b0;
        o_dl_waddr = r_h;
        o_dl_wdata = r_dl;
        o_lk_we    = 1'b0;
        o_lk_waddr = r_h;
        o_lk_wdata = '0;
        unique case (r_state)
            S_INIT: begin
                o_lk_we    = 1'b1;
                o_lk_waddr = r_ptr[HW-1:0];
                o_lk_wdata = {1'b0, (r_ptr == '0) ? EMPTY : r_ptr - 1'b1};
                if (r_ptr == LAST_IDX) begin
                    n_ptr   = EMPTY;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_cmd.command)
                        tdq_pkg::CMD_ADD: begin
                            if (i_dis) begin
                                n_res   = '{tdq_pkg::ST_DISABLED, 10'd0, 1'b0, 1'b1};
                                n_state = S_EMIT;
                            end else if (r_free == EMPTY) begin
                                n_res   = '{tdq_pkg::ST_POOL_EMPTY, 10'd0, 1'b0, 1'b1};
                                n_state = S_EMIT;
                            end else begin
                                n_h      = r_free[HW-1:0];
                                n_ptr    = r_free;
                                n_dl     = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                                n_is_add = 1'b1;
                                n_state  = S_ADD_POP;
                            end
                        end
                        tdq_pkg::CMD_CLEAR: begin
                            if (i_dis) begin
                                n_res   = '{tdq_pkg::ST_DISABLED, 10'd0, 1'b0, 1'b1};
                                n_state = S_EMIT;
                            end else if (32'(i_cmd.handle_in) >= 32'(NUM_TIMERS)) begin
                                n_res   = '{tdq_pkg::ST_NOT_ACTIVE, i_cmd.handle_in,
                                            1'b0, 1'b1};
                                n_state = S_EMIT;
                            end else begin
                                n_h      = HW'(i_cmd.handle_in);
                                n_ptr    = LW'(i_cmd.handle_in);
                                n_is_add = 1'b0;
                                n_state  = S_CLR_CHK;
                            end
                        end
                        tdq_pkg::CMD_SET_TIME: begin
                            n_now   = TIME_BITS'(i_cmd.time_us);
                            n_res   = '{tdq_pkg::ST_OK, 10'd0, 1'b0, 1'b1};
                            n_state = S_EMIT;
                        end
                        tdq_pkg::CMD_DISPATCH: begin
                            n_ptr    = r_head;
                            n_n      = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_DCHK;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_POP: begin
                n_free     = lk_link;
                o_dl_we    = 1'b1;
                n_ptr      = r_head;
                n_prev     = EMPTY;
                n_state    = S_WALK;
            end
            S_CLR_CHK: begin
                if (!lk_act) begin
                    n_res   = '{tdq_pkg::ST_NOT_ACTIVE, 10'(r_h), 1'b0, 1'b1};
                    n_state = S_EMIT;
                end else begin
                    n_hlink = lk_link;
                    n_ptr   = r_head;
                    n_prev  = EMPTY;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (stop) begin
                    n_state = S_LINK1;
                end else begin
                    n_prev = r_ptr;
                    n_ptr  = lk_link;
                end
            end
            S_LINK1: begin
                o_lk_we = 1'b1;
                if (r_is_add) begin
                    o_lk_wdata = {1'b1, r_ptr};
                end else begin
                    o_lk_wdata = {1'b0, r_free};
                    n_free     = {1'b0, r_h};
                end
                n_state = S_LINK2;
            end
            S_LINK2: begin
                if (r_prev == EMPTY) begin
                    n_head = new_link;
                end else begin
                    o_lk_we    = 1'b1;
                    o_lk_waddr = r_prev[HW-1:0];
                    o_lk_wdata = {1'b1, new_link};
                end
                n_res   = '{tdq_pkg::ST_OK, 10'(r_h), 1'b0, 1'b1};
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_slot_free) begin
                    o_emit  = '{1'b1, r_res};
                    n_state = S_IDLE;
                end
            end
            S_DCHK: begin
                if ((fire && !r_pend_v) || i_slot_free) begin
                    if (fire) begin
                        if (r_pend_v) begin
                            o_emit = '{1'b1, '{tdq_pkg::ST_OK, 10'(r_pend), 1'b1, 1'b0}};
                        end
                        o_lk_we    = 1'b1;
                        o_lk_waddr = r_ptr[HW-1:0];
                        o_lk_wdata = {1'b0, r_free};
                        n_free     = r_ptr;
                        n_pend     = r_ptr[HW-1:0];
                        n_pend_v   = 1'b1;
                        n_n        = r_n + 1'b1;
                        n_head     = lk_link;
                        n_ptr      = lk_link;
                    end else begin
                        if (r_pend_v) begin
                            o_emit = '{1'b1, '{tdq_pkg::ST_OK, 10'(r_pend), 1'b1, 1'b1}};
                        end else begin
                            o_emit = '{1'b1, '{tdq_pkg::ST_OK, 10'd0, 1'b0, 1'b1}};
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_raddr = idx(n_ptr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr   <= '0;
            r_head  <= EMPTY;
            r_free  <= LAST_IDX;
            r_now   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_head  <= n_head;
            r_free  <= n_free;
            r_now   <= n_now;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev   <= n_prev;
        r_dl     <= n_dl;
        r_h      <= n_h;
        r_hlink  <= n_hlink;
        r_is_add <= n_is_add;
        r_n      <= n_n;
        r_pend   <= n_pend;
        r_pend_v <= n_pend_v;
        r_res    <= n_res;
    end

`ifndef SYNTHESIS
    a_fire_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DCHK |-> r_n <= FIRE_MAX)
        else $error("dispatch fired more than allowed");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted a second item back to back");
    a_fired_from_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid && o_emit.res.fired |-> r_state == S_DCHK && r_pend_v)
        else $error("fired result outside dispatch");
`endif
endmodule
`default_nettype wire

/* rtl/sorted_deadline_timer_queue_unit.sv */
// top level of the sorted deadline timer queue
//
//  channel   dir  handshake      payload
//  i_cmd     in   valid/ready    command, delay_us, handle_in, time_us
//  o_res     out  valid/ready    status, handle_out, fired, last
//  i_cfg     in   valid/ready    timers_disabled
//
// one item at a time; add and clear walk the sorted list entry by entry, and dispatch
// pops the fired timers from the head of the list one by one
// the list walk reads one entry per cycle from the link and deadline rams
// after reset an init pass over every entry builds the free list before i_cmd is ready
// a stalled o_res holds the sequencer at its next result
`default_nettype none
module sorted_deadline_timer_queue_unit #(
    parameter int NUM_TIMERS = 1024,
    parameter int TIME_BITS  = 48,
    parameter int MAX_FIRE   = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tdq_in_if.sink      i_cmd,
    tdq_out_if.source   o_res,
    tdq_cfg_if.sink     i_cfg
);
    localparam int HW = $clog2(NUM_TIMERS);

    tdq_pkg::t_cmd  cmd;
    tdq_pkg::t_emit emit;
    tdq_pkg::t_res  r_out;
    logic           r_out_v;
    logic           r_dis;
    logic           slot_free;

    logic                 dl_we, lk_we;
    logic [HW-1:0]        dl_waddr, lk_waddr, raddr;
    logic [TIME_BITS-1:0] dl_wdata, dl_rdata;
    logic [HW+1:0]        lk_wdata, lk_rdata;

    assign cmd       = '{i_cmd.command, i_cmd.delay_us, i_cmd.handle_in, i_cmd.time_us};
    assign slot_free = !r_out_v || o_res.ready;

    tdq_ctrl #(
        .NUM_TIMERS(NUM_TIMERS),
        .TIME_BITS (TIME_BITS),
        .MAX_FIRE  (MAX_FIRE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_cmd      (cmd),
        .i_dis      (r_dis),
        .i_slot_free(slot_free),
        .o_emit     (emit),
        .o_dl_we    (dl_we),
        .o_dl_waddr (dl_waddr),
        .o_dl_wdata (dl_wdata),
        .o_lk_we    (lk_we),
        .o_lk_waddr (lk_waddr),
        .o_lk_wdata (lk_wdata),
        .o_raddr    (raddr),
        .i_dl_rdata (dl_rdata),
        .i_lk_rdata (lk_rdata)
    );

    tdq_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_TIMERS)) u_deadline_ram (
        .i_clk  (i_clk),
        .i_we   (dl_we),
        .i_waddr(dl_waddr),
        .i_wdata(dl_wdata),
        .i_raddr(raddr),
        .o_rdata(dl_rdata)
    );

    // active flag and next link share one word
    tdq_ram #(.WIDTH(HW + 2), .DEPTH(NUM_TIMERS)) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (lk_we),
        .i_waddr(lk_waddr),
        .i_wdata(lk_wdata),
        .i_raddr(raddr),
        .o_rdata(lk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_dis   <= 1'b0;
        end else begin
            if (emit.valid) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_dis <= i_cfg.timers_disabled;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out <= emit.res;
        end
    end

    assign i_cfg.ready      = 1'b1;
    assign o_res.valid      = r_out_v;
    assign o_res.status     = r_out.status;
    assign o_res.handle_out = r_out.handle_out;
    assign o_res.fired      = r_out.fired;
    assign o_res.last       = r_out.last;
endmodule
`default_nettype wire
